### hw/rtl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared codes, field positions and types of the trap entry and return unit.
// ----------------------------------------------------------------------------
package rte_pkg;

   // action codes
   localparam logic [1:0] ACT_TRAP = 2'd0;
   localparam logic [1:0] ACT_SRET = 2'd1;
   localparam logic [1:0] ACT_MRET = 2'd2;
   localparam logic [1:0] ACT_BAD  = 2'd3;

   // privilege levels
   localparam logic [1:0] LVL_USER    = 2'd0;
   localparam logic [1:0] LVL_SUPER   = 2'd1;
   localparam logic [1:0] LVL_MACHINE = 2'd3;

   // status word layout
   localparam int unsigned STATUS_W  = 13;
   localparam int unsigned ST_SIE    = 1;
   localparam int unsigned ST_MIE    = 3;
   localparam int unsigned ST_SPIE   = 5;
   localparam int unsigned ST_MPIE   = 7;
   localparam int unsigned ST_SPP    = 8;
   localparam int unsigned ST_MPP_LO = 11;
   localparam int unsigned ST_MPP_HI = 12;

   // register port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MVEC = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SVEC = 4'h8;

   typedef struct packed {
      logic [1:0]          level;
      logic [STATUS_W-1:0] status;
      logic                bad;
   } rte_flags_type;

endpackage

### hw/rtl/rte_if.sv
// ----------------------------------------------------------------------------
// rte_req_if / rte_rsp_if
// Valid/ready channels carrying trap requests and their results.
// ----------------------------------------------------------------------------
interface rte_req_if #(
   parameter int XLEN = 64
);
   logic            valid;
   logic            ready;
   logic [1:0]      action;
   logic [XLEN-1:0] pc;
   logic [1:0]      target_level;
   logic [XLEN-1:0] trap_cause;
   logic [XLEN-1:0] trap_value;

   modport source (
      output valid, action, pc, target_level, trap_cause, trap_value,
      input  ready
   );
   modport sink (
      input  valid, action, pc, target_level, trap_cause, trap_value,
      output ready
   );
endinterface

interface rte_rsp_if #(
   parameter int XLEN = 64
);
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] next_pc;
   logic [1:0]      level_now;
   logic [12:0]     status_word;
   logic            bad_action;

   modport source (
      output valid, next_pc, level_now, status_word, bad_action,
      input  ready
   );
   modport sink (
      input  valid, next_pc, level_now, status_word, bad_action,
      output ready
   );
endinterface

### hw/rtl/rte_csr.sv
// ----------------------------------------------------------------------------
// rte_csr
// APB register block holding the machine and supervisor trap vectors.
// ----------------------------------------------------------------------------
module rte_csr #(
   parameter int XLEN = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rte_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rte_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rte_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [XLEN-1:0]                 mvec,
   output logic [XLEN-1:0]                 svec
);
   import rte_pkg::*;

   logic            wr_en;
   logic [XLEN-1:0] mvec_ff, mvec_in;
   logic [XLEN-1:0] svec_ff, svec_in;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      mvec_in = mvec_ff;
      svec_in = svec_ff;
      if (wr_en && paddr == CSR_ADDR_MVEC) begin
         mvec_in = pwdata[XLEN-1:0];
      end
      if (wr_en && paddr == CSR_ADDR_SVEC) begin
         svec_in = pwdata[XLEN-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvec_ff <= '0;
         svec_ff <= '0;
      end else begin
         mvec_ff <= mvec_in;
         svec_ff <= svec_in;
      end
   end

   always_comb begin
      case (paddr)
         CSR_ADDR_MVEC: prdata = CSR_DATA_W'(mvec_ff);
         CSR_ADDR_SVEC: prdata = CSR_DATA_W'(svec_ff);
         default:       prdata = '0;
      endcase
   end

   assign mvec = mvec_ff;
   assign svec = svec_ff;

endmodule

### hw/rtl/rte_core.sv
// ----------------------------------------------------------------------------
// rte_core
// Privilege, status and trap registers with the combinational update logic.
// ----------------------------------------------------------------------------
module rte_core #(
   parameter int XLEN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            req_action,
   input  logic [XLEN-1:0]       req_pc,
   input  logic [1:0]            req_target,
   input  logic [XLEN-1:0]       req_cause,
   input  logic [XLEN-1:0]       req_tval,
   input  logic [XLEN-1:0]       mvec,
   input  logic [XLEN-1:0]       svec,
   output logic [XLEN-1:0]       res_next_pc,
   output rte_pkg::rte_flags_type res_flags
);
   import rte_pkg::*;

   logic [1:0]          level_ff, level_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [XLEN-1:0]     mepc_ff, mcause_ff, mtval_ff;
   logic [XLEN-1:0]     sepc_ff, scause_ff, stval_ff;
   logic [XLEN-1:0]     next_pc;
   logic                bad;
   logic                s_upd, m_upd;

   always_comb begin
      level_in  = level_ff;
      status_in = status_ff;
      next_pc   = req_pc;
      bad       = 1'b0;
      s_upd     = 1'b0;
      m_upd     = 1'b0;
      case (req_action)
         ACT_TRAP: begin
            if (req_target == LVL_SUPER) begin
               status_in[ST_SPP]  = (level_ff != LVL_USER);
               status_in[ST_SPIE] = status_ff[ST_SIE];
               status_in[ST_SIE]  = 1'b0;
               level_in           = LVL_SUPER;
               next_pc            = svec;
               s_upd              = 1'b1;
            end else begin
               status_in[ST_MPP_HI:ST_MPP_LO] = level_ff;
               status_in[ST_MPIE]             = status_ff[ST_MIE];
               status_in[ST_MIE]              = 1'b0;
               level_in                       = LVL_MACHINE;
               next_pc                        = mvec;
               m_upd                          = 1'b1;
            end
         end
         ACT_SRET: begin
            level_in          = status_ff[ST_SPP] ? LVL_SUPER : LVL_USER;
            status_in[ST_SIE] = status_ff[ST_SPIE];
            next_pc           = sepc_ff;
         end
         ACT_MRET: begin
            level_in          = status_ff[ST_MPP_HI:ST_MPP_LO];
            status_in[ST_MIE] = status_ff[ST_MPIE];
            next_pc           = mepc_ff;
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LVL_MACHINE;
         status_ff <= '0;
         mepc_ff   <= '0;
         mcause_ff <= '0;
         mtval_ff  <= '0;
         sepc_ff   <= '0;
         scause_ff <= '0;
         stval_ff  <= '0;
      end else if (accept) begin
         level_ff  <= level_in;
         status_ff <= status_in;
         if (s_upd) begin
            sepc_ff   <= req_pc;
            scause_ff <= req_cause;
            stval_ff  <= req_tval;
         end
         if (m_upd) begin
            mepc_ff   <= req_pc;
            mcause_ff <= req_cause;
            mtval_ff  <= req_tval;
         end
      end
   end

   assign res_next_pc      = next_pc;
   assign res_flags.level  = level_in;
   assign res_flags.status = status_in;
   assign res_flags.bad    = bad;

   // mpp only records user, supervisor or machine
   a_level_legal: assert property (@(posedge clock) disable iff (reset)
      level_ff != 2'd2)
      else $error("privilege level reached reserved code");

   a_bad_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_BAD |=> $stable(level_ff) && $stable(status_ff))
      else $error("bad action changed state");

   a_strap_masks: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_TRAP && req_target == LVL_SUPER
      |=> level_ff == LVL_SUPER && !status_ff[ST_SIE])
      else $error("supervisor trap did not enter s mode with sie clear");

   a_mtrap_masks: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_TRAP && req_target != LVL_SUPER
      |=> level_ff == LVL_MACHINE && !status_ff[ST_MIE])
      else $error("machine trap did not enter m mode with mie clear");

endmodule

### hw/rtl/rte_skid.sv
// ----------------------------------------------------------------------------
// rte_skid
// Result register with a skid stage that takes one more request under stall.
// ----------------------------------------------------------------------------
module rte_skid #(
   parameter int WIDTH = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] skid_data_ff;
   logic             push;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid & in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || out_ready) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds data while result register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("request under stall not caught by skid stage");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid stage did not drain into result register");

endmodule

### hw/rtl/riscv_trap_entry_return.sv
// ----------------------------------------------------------------------------
// riscv_trap_entry_return
// RISC-V trap entry, SRET and MRET unit for supervisor and machine mode.
// ----------------------------------------------------------------------------
// usage
//   req_ch : valid/ready request channel (action, pc, target level, cause, tval)
//   rsp_ch : valid/ready result channel (next pc, level, status word, bad flag)
//   csr_*  : apb port, trap vector for m mode at 0x0, for s mode at 0x8
// timing
//   one request per cycle sustained while rsp_ch.ready holds; each request
//   is applied to the privilege and status registers in the cycle it is
//   accepted, and its result is registered in the result register; the
//   result register plus one skid entry absorb a stalled receiver: after
//   two results pile up req_ch.ready drops until rsp_ch.ready returns
// reset
//   synchronous; machine mode, status word and saved epc/cause/tval cleared,
//   both trap vectors zero, no result pending
//   write the vectors only while no request is in flight
// ----------------------------------------------------------------------------
module riscv_trap_entry_return #(
   parameter int XLEN = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   rte_req_if.sink                        req_ch,
   rte_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rte_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rte_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rte_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rte_pkg::*;

   localparam int RSP_W = XLEN + $bits(rte_flags_type);

   logic [XLEN-1:0]  mvec, svec;
   logic [XLEN-1:0]  res_next_pc;
   rte_flags_type    res_flags;
   rte_flags_type    out_flags;
   logic             accept;
   logic             in_ready;
   logic [RSP_W-1:0] rsp_data;

   rte_csr #(.XLEN(XLEN)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .mvec    (mvec),
      .svec    (svec)
   );

   assign req_ch.ready = in_ready;
   assign accept       = req_ch.valid & in_ready;

   rte_core #(.XLEN(XLEN)) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_action  (req_ch.action),
      .req_pc      (req_ch.pc),
      .req_target  (req_ch.target_level),
      .req_cause   (req_ch.trap_cause),
      .req_tval    (req_ch.trap_value),
      .mvec        (mvec),
      .svec        (svec),
      .res_next_pc (res_next_pc),
      .res_flags   (res_flags)
   );

   rte_skid #(.WIDTH(RSP_W)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (in_ready),
      .in_data   ({res_next_pc, res_flags}),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.next_pc     = rsp_data[RSP_W-1 -: XLEN];
   assign out_flags          = rsp_data[$bits(rte_flags_type)-1:0];
   assign rsp_ch.level_now   = out_flags.level;
   assign rsp_ch.status_word = out_flags.status;
   assign rsp_ch.bad_action  = out_flags.bad;

endmodule

### tb/tb_riscv_trap_entry_return.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_riscv_trap_entry_return
// Self-checking bench for the trap entry, SRET and MRET unit. A behavioral
// copy of the privilege, status and epc/cause/tval registers predicts every
// result. Each response is compared field by field, in order, against that
// prediction. Directed sequences walk through all privilege transitions.
// Random traffic follows under several trap vector settings, with random
// idle cycles on both channels except in the steady stream test.
// ----------------------------------------------------------------------------
module tb_riscv_trap_entry_return;
   import rte_pkg::*;

   localparam int XLEN           = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 100;

   typedef struct packed {
      logic [1:0]      action;
      logic [XLEN-1:0] pc;
      logic [1:0]      target_level;
      logic [XLEN-1:0] trap_cause;
      logic [XLEN-1:0] trap_value;
   } trap_req_type;

   typedef struct packed {
      logic [XLEN-1:0]     next_pc;
      logic [1:0]          level_now;
      logic [STATUS_W-1:0] status_word;
      logic                bad_action;
   } trap_rsp_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   rte_req_if #(.XLEN(XLEN)) req_bus ();
   rte_rsp_if #(.XLEN(XLEN)) rsp_bus ();

   riscv_trap_entry_return #(.XLEN(XLEN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted architectural state
   logic [1:0]          cur_level;
   logic [STATUS_W-1:0] cur_status;
   logic [XLEN-1:0]     m_epc, m_cause, m_tval;
   logic [XLEN-1:0]     s_epc, s_cause, s_tval;
   logic [XLEN-1:0]     m_vector, s_vector;

   trap_rsp_type expected_trap_results[$];

   bit steady;
   int error_count;
   int reports;
   int req_taken;
   int csr_taken;
   int quiet_cycles;
   int rsp_checked;
   int n_trap_s, n_trap_m, n_sret, n_mret, n_bad, n_user, n_vec_writes;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic trap_rsp_type predict_trap_result(input trap_req_type r);
      trap_rsp_type res;
      res.next_pc    = r.pc;
      res.bad_action = 1'b0;
      case (r.action)
         ACT_TRAP: begin
            if (r.target_level == LVL_SUPER) begin
               cur_status[ST_SPP]  = (cur_level != LVL_USER);
               cur_status[ST_SPIE] = cur_status[ST_SIE];
               cur_status[ST_SIE]  = 1'b0;
               cur_level = LVL_SUPER;
               s_epc   = r.pc;
               s_cause = r.trap_cause;
               s_tval  = r.trap_value;
               res.next_pc = s_vector;
               n_trap_s++;
            end else begin
               cur_status[ST_MPP_HI:ST_MPP_LO] = cur_level;
               cur_status[ST_MPIE] = cur_status[ST_MIE];
               cur_status[ST_MIE]  = 1'b0;
               cur_level = LVL_MACHINE;
               m_epc   = r.pc;
               m_cause = r.trap_cause;
               m_tval  = r.trap_value;
               res.next_pc = m_vector;
               n_trap_m++;
            end
         end
         ACT_SRET: begin
            cur_level = cur_status[ST_SPP] ? LVL_SUPER : LVL_USER;
            cur_status[ST_SIE] = cur_status[ST_SPIE];
            res.next_pc = s_epc;
            n_sret++;
         end
         ACT_MRET: begin
            cur_level = cur_status[ST_MPP_HI:ST_MPP_LO];
            cur_status[ST_MIE] = cur_status[ST_MPIE];
            res.next_pc = m_epc;
            n_mret++;
         end
         default: begin
            res.bad_action = 1'b1;
            n_bad++;
         end
      endcase
      if (cur_level == LVL_USER) n_user++;
      res.level_now   = cur_level;
      res.status_word = cur_status;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [XLEN-1:0] want,
                                  input logic [XLEN-1:0] got);
      error_count++;
      if (reports < MAX_REPORTS) begin
         reports++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // monitor, checker and watchdog
   always @(posedge clock) begin
      trap_rsp_type got;
      trap_rsp_type want;
      logic [XLEN-1:0] vec;
      bit busy;
      if (!reset) begin
         busy = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            busy = 1'b1;
            got.next_pc     = rsp_bus.next_pc;
            got.level_now   = rsp_bus.level_now;
            got.status_word = rsp_bus.status_word;
            got.bad_action  = rsp_bus.bad_action;
            if (expected_trap_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, next_pc %h", $time, got.next_pc);
            end else begin
               want = expected_trap_results.pop_front();
               rsp_checked++;
               if (got.next_pc !== want.next_pc)
                  report_mismatch("next_pc", want.next_pc, got.next_pc);
               if (got.level_now !== want.level_now)
                  report_mismatch("level_now", want.level_now, got.level_now);
               if (got.status_word !== want.status_word)
                  report_mismatch("status_word", want.status_word, got.status_word);
               if (got.bad_action !== want.bad_action)
                  report_mismatch("bad_action", want.bad_action, got.bad_action);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            busy = 1'b1;
            req_taken++;
            expected_trap_results.push_back(predict_trap_result('{
               action: req_bus.action, pc: req_bus.pc,
               target_level: req_bus.target_level,
               trap_cause: req_bus.trap_cause, trap_value: req_bus.trap_value}));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            busy = 1'b1;
            csr_taken++;
            if (csr_pwrite) begin
               n_vec_writes++;
               if (csr_paddr == CSR_ADDR_MVEC) m_vector = csr_pwdata;
               else if (csr_paddr == CSR_ADDR_SVEC) s_vector = csr_pwdata;
            end else begin
               vec = (csr_paddr == CSR_ADDR_MVEC) ? m_vector : s_vector;
               if (csr_prdata !== vec) report_mismatch("csr readback", vec, csr_prdata);
            end
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready = steady || ($urandom_range(99) >= 37);
   end

   function automatic logic [XLEN-1:0] random_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic trap_req_type make_req(input logic [1:0] act, input logic [1:0] lvl,
                                             input logic [XLEN-1:0] pc,
                                             input logic [XLEN-1:0] cause,
                                             input logic [XLEN-1:0] tval);
      trap_req_type r;
      r.action = act;
      r.target_level = lvl;
      r.pc = pc;
      r.trap_cause = cause;
      r.trap_value = tval;
      return r;
   endfunction

   function automatic trap_req_type random_request();
      int unsigned pick;
      logic [1:0] act;
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_TRAP;
      else if (pick < 65) act = ACT_SRET;
      else if (pick < 90) act = ACT_MRET;
      else act = ACT_BAD;
      return make_req(act, 2'($urandom_range(3)), random_word(), random_word(),
                      random_word());
   endfunction

   // all tasks start and end on a falling edge
   task automatic send_request(input trap_req_type r);
      int goal;
      if (!steady && $urandom_range(99) < 37) begin
         req_bus.valid = 1'b0;
         do @(negedge clock); while (!steady && $urandom_range(99) < 37);
      end
      req_bus.action       = r.action;
      req_bus.pc           = r.pc;
      req_bus.target_level = r.target_level;
      req_bus.trap_cause   = r.trap_cause;
      req_bus.trap_value   = r.trap_value;
      req_bus.valid        = 1'b1;
      goal = req_taken + 1;
      while (req_taken < goal) @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_trap_results.size() != 0) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      int goal;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      goal = csr_taken + 1;
      while (csr_taken < goal) @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_trap_vectors(input logic [XLEN-1:0] mv, input logic [XLEN-1:0] sv);
      drain_results();
      repeat (2) @(negedge clock);
      csr_access(1'b1, CSR_ADDR_MVEC, mv);
      csr_access(1'b1, CSR_ADDR_SVEC, sv);
      csr_access(1'b0, CSR_ADDR_MVEC, '0);
      csr_access(1'b0, CSR_ADDR_SVEC, '0);
   endtask

   task automatic test_directed_modes();
      trap_req_type seq[$];
      seq.push_back(make_req(ACT_BAD,  LVL_USER,    '1, '1, '1));   // reset state shown
      seq.push_back(make_req(ACT_MRET, LVL_USER,    '0, '0, '0));   // mpp 0, drop to user
      seq.push_back(make_req(ACT_TRAP, 2'd2,        64'h1000, 64'h8, 64'h0));  // u to m
      seq.push_back(make_req(ACT_MRET, LVL_MACHINE, '0, '0, '0));
      seq.push_back(make_req(ACT_TRAP, LVL_SUPER,   '1, '1, '0));   // u to s, spp 0
      seq.push_back(make_req(ACT_SRET, LVL_SUPER,   '0, '0, '0));   // back to user
      seq.push_back(make_req(ACT_TRAP, LVL_SUPER,   64'h2000, 64'hd, 64'h55));
      seq.push_back(make_req(ACT_TRAP, LVL_SUPER,   64'h2004, 64'hf, 64'haa));  // s to s
      seq.push_back(make_req(ACT_SRET, LVL_USER,    '1, '1, '1));   // spp 1, stay s
      seq.push_back(make_req(ACT_TRAP, LVL_MACHINE, 64'h3000, '1, '1));  // s to m
      seq.push_back(make_req(ACT_MRET, LVL_SUPER,   '0, '0, '0));
      seq.push_back(make_req(ACT_TRAP, LVL_USER,    '0, '0, '1));   // target 0 goes to m
      seq.push_back(make_req(ACT_TRAP, 2'd2,        '1, '0, '0));   // m to m, mpp 3
      seq.push_back(make_req(ACT_TRAP, LVL_SUPER,   64'h4000, 64'h2, 64'h7));  // m to s
      seq.push_back(make_req(ACT_MRET, LVL_USER,    '0, '0, '0));
      seq.push_back(make_req(ACT_BAD,  LVL_SUPER,   64'h5a5a, '1, '0));
      seq.push_back(make_req(ACT_SRET, LVL_MACHINE, '0, '0, '0));
      seq.push_back(make_req(ACT_TRAP, LVL_MACHINE, '0, '1, '1));
      seq.push_back(make_req(ACT_MRET, 2'd2,        '1, '1, '1));
      foreach (seq[i]) send_request(seq[i]);
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic test_steady_stream(input int count);
      drain_results();
      steady = 1'b1;
      test_random_traffic(count);
      drain_results();
      steady = 1'b0;
   endtask

   task automatic test_sender_drain(input int count);
      test_random_traffic(count / 2);
      drain_results();
      test_random_traffic(count - count / 2);
   endtask

   initial begin
      reset = 1'b1;
      steady = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_TRAP;
      req_bus.pc = '0;
      req_bus.target_level = LVL_USER;
      req_bus.trap_cause = '0;
      req_bus.trap_value = '0;
      rsp_bus.ready = 1'b0;
      cur_level = LVL_MACHINE;
      cur_status = '0;
      {m_epc, m_cause, m_tval, s_epc, s_cause, s_tval} = '0;
      m_vector = '0;
      s_vector = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      set_trap_vectors(64'h8000_0000_0000_0100, 64'h8000_0000_0000_0200);
      test_directed_modes();
      set_trap_vectors('0, '1);
      test_random_traffic(300);
      set_trap_vectors('1, '0);
      test_steady_stream(250);
      set_trap_vectors({$urandom, $urandom}, {$urandom, $urandom});
      test_random_traffic(300);
      test_sender_drain(150);
      set_trap_vectors({$urandom, $urandom}, {$urandom, $urandom});
      test_random_traffic(200);

      drain_results();
      repeat (4) @(negedge clock);
      if (expected_trap_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, expected_trap_results.size());
      end
      $display("ran %0d requests: %0d s-mode traps, %0d m-mode traps,",
               req_taken, n_trap_s, n_trap_m);
      $display("  %0d sret, %0d mret, %0d invalid", n_sret, n_mret, n_bad);
      $display("checked %0d results (%0d in user mode), %0d trap vector writes, %0d errors",
               rsp_checked, n_user, n_vec_writes, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
